// ===== design/rmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants for the rotation matrix to quaternion converter
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DEF_FRAC_BITS = 14;
  localparam int ELEM_W        = 16;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] qw;
    logic signed [ELEM_W-1:0] qx;
    logic signed [ELEM_W-1:0] qy;
    logic signed [ELEM_W-1:0] qz;
  } out_t;

  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } branch_t;

endpackage
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// converts a 3x3 rotation matrix into a saturated unit quaternion
// ----------------------------------------------------------------------------
//  channel | ports              | content
//  in      | in_valid/in_ready  | in_data : nine matrix elements
//  out     | out_valid/out_ready| out_data: qw qx qy qz
//
//  one matrix per cycle while the output is not stalled; the pipeline is a
//  bit-per-stage square root followed by three bit-per-stage dividers
//  synchronous reset clears the valid bits only
//  a stall at the output freezes every stage at once
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = rmq_pkg::DEF_FRAC_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire rmq_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output rmq_pkg::out_t     out_data
);
  import rmq_pkg::*;

  localparam int RS  = ((FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19) + 1;
  localparam int RW  = RS - 1;
  localparam int OPW = RW + FRAC_BITS;
  localparam int SW  = (OPW + 1) / 2;
  localparam int NW  = 17 + FRAC_BITS;
  localparam int CW  = (NW > SW + FRAC_BITS + 2) ? NW : SW + FRAC_BITS + 2;
  localparam int QW  = FRAC_BITS + 2;
  localparam int DN  = FRAC_BITS + 2;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // front end: branch choice, radicand and numerators
  logic signed [RS-1:0] e00, e11, e22, tr, rad_s, one_s;
  logic [RW-1:0]        rad0;
  branch_t              sel0;
  logic signed [16:0]   nwx, nwy, nwz, nxy, nxz, nyz;
  logic signed [16:0]   n0 [3];

  always_comb begin
    one_s = {{(RS-1){1'b0}}, 1'b1} << FRAC_BITS;
    e00   = RS'(in_data.m00);
    e11   = RS'(in_data.m11);
    e22   = RS'(in_data.m22);
    tr    = e00 + e11 + e22;
    nwx   = 17'(in_data.m21) - 17'(in_data.m12);
    nwy   = 17'(in_data.m02) - 17'(in_data.m20);
    nwz   = 17'(in_data.m10) - 17'(in_data.m01);
    nxy   = 17'(in_data.m01) + 17'(in_data.m10);
    nxz   = 17'(in_data.m02) + 17'(in_data.m20);
    nyz   = 17'(in_data.m12) + 17'(in_data.m21);
    priority if (tr > 0) begin
      sel0  = BR_W;
      rad_s = one_s + tr;
      n0[0] = nwx; n0[1] = nwy; n0[2] = nwz;
    end else if (e00 > e11 && e00 > e22) begin
      sel0  = BR_X;
      rad_s = one_s + e00 - e11 - e22;
      n0[0] = nwx; n0[1] = nxy; n0[2] = nxz;
    end else if (e11 > e22) begin
      sel0  = BR_Y;
      rad_s = one_s + e11 - e00 - e22;
      n0[0] = nwy; n0[1] = nxy; n0[2] = nyz;
    end else begin
      sel0  = BR_Z;
      rad_s = one_s + e22 - e00 - e11;
      n0[0] = nwz; n0[1] = nxz; n0[2] = nyz;
    end
    if (rad_s <= 0) begin
      rad0 = RW'(1);
    end else begin
      rad0 = rad_s[RW-1:0];
    end
  end

  // square root pipeline, one root bit per stage
  logic               sq_v_r    [SW+1];
  logic [RW-1:0]      sq_rad_r  [SW+1];
  logic [SW+1:0]      sq_rem_r  [SW+1];
  logic [SW-1:0]      sq_root_r [SW+1];
  branch_t            sq_sel_r  [SW+1];
  logic signed [16:0] sq_n_r    [SW+1][3];
  logic [SW+1:0]      sq_rem_nxt  [SW+1];
  logic [SW-1:0]      sq_root_nxt [SW+1];

  assign sq_rem_nxt[0]  = '0;
  assign sq_root_nxt[0] = '0;

  for (genvar i = 0; i < SW; i++) begin : g_sq
    logic [2*SW-1:0] op;
    logic [SW+3:0]   rem_sh, trial, diff;
    always_comb begin
      op     = (2*SW)'({sq_rad_r[i], {FRAC_BITS{1'b0}}});
      rem_sh = {sq_rem_r[i], op[2*SW-1-2*i -: 2]};
      trial  = {2'b00, sq_root_r[i], 2'b01};
      diff   = rem_sh - trial;
      if (rem_sh >= trial) begin
        sq_rem_nxt[i+1]  = diff[SW+1:0];
        sq_root_nxt[i+1] = {sq_root_r[i][SW-2:0], 1'b1};
      end else begin
        sq_rem_nxt[i+1]  = rem_sh[SW+1:0];
        sq_root_nxt[i+1] = {sq_root_r[i][SW-2:0], 1'b0};
      end
    end
  end

  // divider set-up and restoring division, one quotient bit per stage
  logic               dv_v_r   [DN+1];
  logic [SW:0]        dv_den_r [DN+1];
  branch_t            dv_sel_r [DN+1];
  logic [CW-1:0]      dv_rem_r [DN+1][3];
  logic [QW-1:0]      dv_q_r   [DN+1][3];
  logic               dv_neg_r [DN+1][3];
  logic               dv_ovf_r [DN+1][3];
  logic [CW-1:0]      dv_rem_nxt [DN+1][3];
  logic [QW-1:0]      dv_q_nxt   [DN+1][3];
  logic               su_ovf [3];
  logic [SW:0]        su_den;

  assign su_den = {sq_root_r[SW], 1'b0};

  for (genvar c = 0; c < 3; c++) begin : g_su
    logic [16:0] mag;
    always_comb begin
      mag = sq_n_r[SW][c][16] ? 17'(-sq_n_r[SW][c]) : 17'(sq_n_r[SW][c]);
      dv_rem_nxt[0][c] = (CW'(mag) << FRAC_BITS) + CW'(sq_root_r[SW]);
      dv_q_nxt[0][c]   = '0;
      su_ovf[c]        = dv_rem_nxt[0][c] >= (CW'(su_den) << (FRAC_BITS + 1));
    end
  end

  for (genvar j = 0; j < DN; j++) begin : g_dv
    for (genvar c = 0; c < 3; c++) begin : g_c
      logic [CW-1:0] d;
      always_comb begin
        d = CW'(dv_den_r[j]) << (FRAC_BITS + 1 - j);
        if (dv_rem_r[j][c] >= d) begin
          dv_rem_nxt[j+1][c] = dv_rem_r[j][c] - d;
          dv_q_nxt[j+1][c]   = {dv_q_r[j][c][QW-2:0], 1'b1};
        end else begin
          dv_rem_nxt[j+1][c] = dv_rem_r[j][c];
          dv_q_nxt[j+1][c]   = {dv_q_r[j][c][QW-2:0], 1'b0};
        end
      end
    end
  end

  // saturation and output assembly
  logic signed [32:0] one_w, dom_w;
  logic signed [32:0] oth [3];
  out_t               res_nxt;
  out_t               out_data_r;
  logic               out_valid_r;

  for (genvar c = 0; c < 3; c++) begin : g_sat
    logic signed [32:0] mg;
    always_comb begin
      mg = 33'(dv_q_r[DN][c]);
      if (dv_ovf_r[DN][c] || mg > one_w) begin
        mg = one_w;
      end
      oth[c] = dv_neg_r[DN][c] ? -mg : mg;
    end
  end

  always_comb begin
    one_w = 33'(1) << FRAC_BITS;
    dom_w = 33'(dv_den_r[DN] >> 2);
    if (dom_w > one_w) begin
      dom_w = one_w;
    end
    unique case (dv_sel_r[DN])
      BR_W: res_nxt = '{qw: dom_w[15:0], qx: oth[0][15:0], qy: oth[1][15:0],
                        qz: oth[2][15:0]};
      BR_X: res_nxt = '{qw: oth[0][15:0], qx: dom_w[15:0], qy: oth[1][15:0],
                        qz: oth[2][15:0]};
      BR_Y: res_nxt = '{qw: oth[0][15:0], qx: oth[1][15:0], qy: dom_w[15:0],
                        qz: oth[2][15:0]};
      BR_Z: res_nxt = '{qw: oth[0][15:0], qx: oth[1][15:0], qy: oth[2][15:0],
                        qz: dom_w[15:0]};
      default: res_nxt = '0;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= SW; i++) sq_v_r[i] <= 1'b0;
      for (int j = 0; j <= DN; j++) dv_v_r[j] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= in_valid;
      for (int i = 0; i < SW; i++) sq_v_r[i+1] <= sq_v_r[i];
      dv_v_r[0] <= sq_v_r[SW];
      for (int j = 0; j < DN; j++) dv_v_r[j+1] <= dv_v_r[j];
      out_valid_r <= dv_v_r[DN];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad_r[0]  <= rad0;
      sq_rem_r[0]  <= sq_rem_nxt[0];
      sq_root_r[0] <= sq_root_nxt[0];
      sq_sel_r[0]  <= sel0;
      for (int c = 0; c < 3; c++) sq_n_r[0][c] <= n0[c];
      for (int i = 0; i < SW; i++) begin
        sq_rad_r[i+1]  <= sq_rad_r[i];
        sq_rem_r[i+1]  <= sq_rem_nxt[i+1];
        sq_root_r[i+1] <= sq_root_nxt[i+1];
        sq_sel_r[i+1]  <= sq_sel_r[i];
        for (int c = 0; c < 3; c++) sq_n_r[i+1][c] <= sq_n_r[i][c];
      end
      dv_den_r[0] <= su_den;
      dv_sel_r[0] <= sq_sel_r[SW];
      for (int c = 0; c < 3; c++) begin
        dv_rem_r[0][c] <= dv_rem_nxt[0][c];
        dv_q_r[0][c]   <= dv_q_nxt[0][c];
        dv_neg_r[0][c] <= sq_n_r[SW][c][16];
        dv_ovf_r[0][c] <= su_ovf[c];
      end
      for (int j = 0; j < DN; j++) begin
        dv_den_r[j+1] <= dv_den_r[j];
        dv_sel_r[j+1] <= dv_sel_r[j];
        for (int c = 0; c < 3; c++) begin
          dv_rem_r[j+1][c] <= dv_rem_nxt[j+1][c];
          dv_q_r[j+1][c]   <= dv_q_nxt[j+1][c];
          dv_neg_r[j+1][c] <= dv_neg_r[j][c];
          dv_ovf_r[j+1][c] <= dv_ovf_r[j][c];
        end
      end
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/tb_rotation_matrix_to_quaternion_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_top
// checks the matrix to quaternion converter against its own integer predictor,
// with directed corner matrices, random rotations and raw random patterns,
// under several sender and receiver idling mixes
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_top;
  import rmq_pkg::*;

  localparam int FB       = DEF_FRAC_BITS;
  localparam int ONE      = 1 << FB;
  localparam int LATENCY  = 40;
  localparam int WD_LIMIT = 20000;
  localparam int IN_W     = $bits(in_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  out_t quat_q[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  always #2 clk = ~clk;

  rotation_matrix_to_quaternion_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  function automatic longint unsigned int_sqrt(longint unsigned op);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > op) b = b >> 2;
    while (b != 0) begin
      if (op >= res + b) begin
        op = op - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint div_round(longint n, longint unsigned root);
    longint unsigned mag;
    longint unsigned q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = ((mag << FB) + root) / (root * 2);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic out_t predict_quat(in_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, r;
    longint q[4];
    longint unsigned root;
    branch_t br;
    out_t o;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    if (a00 + a11 + a22 > 0) begin
      br = BR_W; r = ONE + a00 + a11 + a22;
    end else if (a00 > a11 && a00 > a22) begin
      br = BR_X; r = ONE + a00 - a11 - a22;
    end else if (a11 > a22) begin
      br = BR_Y; r = ONE + a11 - a00 - a22;
    end else begin
      br = BR_Z; r = ONE + a22 - a00 - a11;
    end
    if (r <= 0) r = 1;
    root = int_sqrt(longint'(r) << FB);
    case (br)
      BR_W: begin
        q[0] = root >> 1;             q[1] = div_round(a21 - a12, root);
        q[2] = div_round(a02 - a20, root); q[3] = div_round(a10 - a01, root);
      end
      BR_X: begin
        q[0] = div_round(a21 - a12, root); q[1] = root >> 1;
        q[2] = div_round(a01 + a10, root); q[3] = div_round(a02 + a20, root);
      end
      BR_Y: begin
        q[0] = div_round(a02 - a20, root); q[1] = div_round(a01 + a10, root);
        q[2] = root >> 1;             q[3] = div_round(a12 + a21, root);
      end
      default: begin
        q[0] = div_round(a10 - a01, root); q[1] = div_round(a02 + a20, root);
        q[2] = div_round(a12 + a21, root); q[3] = root >> 1;
      end
    endcase
    o.qw = 16'(clamp_unit(q[0]));
    o.qx = 16'(clamp_unit(q[1]));
    o.qy = 16'(clamp_unit(q[2]));
    o.qz = 16'(clamp_unit(q[3]));
    return o;
  endfunction

  // receiver side: stall pattern and result check
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    out_t exp_q;
    if (rst_n && out_valid && out_ready) begin
      if (quat_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_q = quat_q.pop_front();
        if (out_data !== exp_q) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch qw %h/%h qx %h/%h qy %h/%h qz %h/%h (exp/act)",
                     exp_q.qw, out_data.qw, exp_q.qx, out_data.qx,
                     exp_q.qy, out_data.qy, exp_q.qz, out_data.qz);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("[rotation_matrix_to_quaternion_top] ERROR");
      $finish;
    end
  end

  task automatic send_matrix(input in_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    quat_q = {quat_q, predict_quat(m)};
    @(negedge clk);
  endtask

  function automatic in_t diag_matrix(int d0, int d1, int d2);
    in_t m;
    m = '0;
    m.m00 = 16'(d0); m.m11 = 16'(d1); m.m22 = 16'(d2);
    return m;
  endfunction

  // random rotation built from a random quaternion in fixed point
  function automatic in_t random_rotation();
    real w, x, y, z, n;
    in_t m;
    w = $urandom_range(2000) - 1000.0; x = $urandom_range(2000) - 1000.0;
    y = $urandom_range(2000) - 1000.0; z = $urandom_range(2000) - 1000.0;
    n = w * w + x * x + y * y + z * z;
    if (n < 1.0) begin
      w = 1.0; n = 1.0;
    end
    m.m00 = 16'($rtoi(ONE * (1.0 - 2.0 * (y * y + z * z) / n)));
    m.m01 = 16'($rtoi(ONE * 2.0 * (x * y - z * w) / n));
    m.m02 = 16'($rtoi(ONE * 2.0 * (x * z + y * w) / n));
    m.m10 = 16'($rtoi(ONE * 2.0 * (x * y + z * w) / n));
    m.m11 = 16'($rtoi(ONE * (1.0 - 2.0 * (x * x + z * z) / n)));
    m.m12 = 16'($rtoi(ONE * 2.0 * (y * z - x * w) / n));
    m.m20 = 16'($rtoi(ONE * 2.0 * (x * z - y * w) / n));
    m.m21 = 16'($rtoi(ONE * 2.0 * (y * z + x * w) / n));
    m.m22 = 16'($rtoi(ONE * (1.0 - 2.0 * (x * x + y * y) / n)));
    return m;
  endfunction

  function automatic in_t random_pattern();
    in_t m;
    m = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return m;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    in_t m;
    send_matrix(diag_matrix(ONE, ONE, ONE));
    send_matrix(diag_matrix(ONE, -ONE, -ONE));
    send_matrix(diag_matrix(-ONE, ONE, -ONE));
    send_matrix(diag_matrix(-ONE, -ONE, ONE));
    // non-positive trace and equal diagonals: ties fall to later branches
    send_matrix(diag_matrix(0, 0, 0));
    send_matrix(diag_matrix(-ONE, -ONE, -ONE));
    send_matrix(diag_matrix(0, 0, -ONE));
    send_matrix(diag_matrix(-ONE, 0, 0));
    // extreme diagonal values, radicand stays positive
    send_matrix(diag_matrix(-32768, -32768, -32768));
    send_matrix(diag_matrix(-32768, 32767, 32767));
    send_matrix(diag_matrix(32767, 32767, -32768));
    // off-diagonal extremes, outputs saturate
    m = diag_matrix(1, 0, -1);
    m.m01 = -32768; m.m10 = 32767; m.m02 = 32767; m.m20 = -32768;
    m.m12 = -32768; m.m21 = 32767;
    send_matrix(m);
    m = diag_matrix(-ONE, -ONE, ONE);
    m.m01 = 32767; m.m10 = 32767; m.m02 = -32768; m.m20 = -32768;
    m.m12 = 32767; m.m21 = 32767;
    send_matrix(m);
    send_matrix('1);
    send_matrix({9{16'h8000}});
    send_matrix({9{16'h7fff}});
    send_matrix({9{16'h5555}});
    send_matrix({9{16'haaaa}});
    wait_drained();
  endtask

  task automatic test_random(input int sender_pct, input int receiver_pct, input int n);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    repeat (n) begin
      if ($urandom_range(99) < 80) send_matrix(random_rotation());
      else send_matrix(random_pattern());
    end
    // sender holds off until everything is back
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    out_ready <= 1'b1;
    test_directed();
    test_random(0, 0, 170);
    test_random(63, 0, 160);
    test_random(0, 63, 160);
    test_random(12, 12, 160);
    if (mismatches == 0 && quat_q.size() == 0)
      $display("[rotation_matrix_to_quaternion_top] OK");
    else
      $display("[rotation_matrix_to_quaternion_top] ERROR");
    $finish;
  end

endmodule
